FILE: rtl/rtp_pkg.sv
// Package for the IPv6 range-to-prefix splitter.
// Holds the item structs, the sequencer command/status structs and the shared constants.
// No dependencies.
package rtp_pkg;

    localparam int unsigned AW = 128;
    localparam int unsigned HW = 64;
    localparam logic [7:0] ADDR_BITS = 8'd128;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] start_hi;
        logic [63:0] start_lo;
        logic [63:0] end_hi;
        logic [63:0] end_lo;
    } req_t;

    typedef struct packed {
        logic [63:0] base_hi;
        logic [63:0] base_lo;
        logic [7:0]  prefix_len;
        logic        last;
        logic        none;
    } resp_t;

    // Operand choice for the shared comparator.
    typedef enum logic [1:0] {
        SEL_CURSOR = 2'd0,
        SEL_BLOCK  = 2'd1,
        SEL_NEXT   = 2'd2
    } cmp_sel_t;

    typedef struct packed {
        logic     load;
        logic     kick;
        logic     shrink;
        logic     advance;
        logic     emit_none;
        cmp_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic le;
        logic aligned;
    } stat_t;

endpackage

FILE: rtl/rtp_le128.sv
// Shared 128-bit unsigned comparator of the prefix splitter.
// Depends on rtp_pkg for the address width.
module rtp_le128 (
    input  logic [rtp_pkg::AW-1:0] a,
    input  logic [rtp_pkg::AW-1:0] b,
    output logic                   le
);
    import rtp_pkg::*;

    assign le = (a <= b);

endmodule

FILE: rtl/rtp_seq.sv
// Sequencer of the prefix splitter: range check, block-size search and cursor step.
// Depends on rtp_pkg for the command and status structs.
module rtp_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           op,
    input  logic           active,
    input  rtp_pkg::stat_t stat,
    output logic           busy,
    output rtp_pkg::cmd_t  cmd
);
    import rtp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_STEP   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_CURSOR;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (!active)
                    begin
                        cmd.emit_none = 1'b1;
                    end
                    else
                    begin
                        cmd.kick   = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.sel = SEL_CURSOR;
                if (stat.le)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                // The first block size that is both aligned and inside the range wins.
                cmd.sel = SEL_BLOCK;
                if (stat.le && stat.aligned)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    cmd.shrink = 1'b1;
                end
            end
            ST_STEP:
            begin
                cmd.sel     = SEL_NEXT;
                cmd.advance = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_step_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |=> state_reg == ST_IDLE)
        else $error("step state held longer than one cycle");

    a_search_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_SEARCH) |-> $past(state_reg) == ST_CHECK)
        else $error("search entered without a range check");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load && !cmd.kick)
        else $error("new item taken while busy");

endmodule

FILE: rtl/ipv6_range_to_prefixes_top.sv
// Top level of the IPv6 range-to-prefix splitter: range registers, search mask and result.
// Depends on rtp_pkg, rtp_le128 and rtp_seq.
// Steps: a load gives no result; a fetch on an inactive range gives an empty result from idle;
// a live fetch runs a range check (an empty result if the cursor is past the limit), then the
// one-bit-a-step block-size search from a 2^128 block down through the shared comparator,
// then the cursor step that registers the prefix result.
// One item at a time: busy stays high until the result is registered.
// rst_n clears the range to empty; results are strobed by resp_valid and cannot be stalled.
module ipv6_range_to_prefixes_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rtp_pkg::req_t  req,
    output logic           resp_valid,
    output rtp_pkg::resp_t resp
);
    import rtp_pkg::*;

    logic [AW-1:0] cursor_reg;
    logic [AW-1:0] limit_reg;
    logic [AW-1:0] mask_reg;
    logic [7:0]    k_reg;
    logic          active_reg;
    resp_t         resp_reg;
    logic          resp_valid_reg;

    cmd_t          cmd;
    stat_t         stat;
    logic [AW-1:0] cmp_a;
    logic          le;
    logic [AW:0]   sum;
    logic          last;

    // Cursor plus block size; the carry bit means the step wrapped past the address space.
    assign sum  = {1'b0, cursor_reg} + {1'b0, mask_reg} + {{AW{1'b0}}, 1'b1};
    assign last = sum[AW] | ~le;

    always_comb
    begin
        case (cmd.sel)
            SEL_CURSOR: cmp_a = cursor_reg;
            SEL_BLOCK:  cmp_a = cursor_reg | mask_reg;
            SEL_NEXT:   cmp_a = sum[AW-1:0];
            default:    cmp_a = cursor_reg;
        endcase
    end

    rtp_le128 u_cmp (
        .a  (cmp_a),
        .b  (limit_reg),
        .le (le)
    );

    assign stat.le      = le;
    assign stat.aligned = ((cursor_reg & mask_reg) == '0);

    rtp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (req.op),
        .active (active_reg),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            limit_reg      <= '0;
            mask_reg       <= '0;
            k_reg          <= '0;
            active_reg     <= 1'b0;
            resp_reg       <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            resp_valid_reg <= cmd.emit_none | cmd.advance;
            if (cmd.load)
            begin
                cursor_reg <= {req.start_hi, req.start_lo};
                limit_reg  <= {req.end_hi, req.end_lo};
                active_reg <= 1'b1;
            end
            if (cmd.kick)
            begin
                mask_reg <= '1;
                k_reg    <= ADDR_BITS;
            end
            if (cmd.shrink)
            begin
                mask_reg <= mask_reg >> 1;
                k_reg    <= k_reg - 8'd1;
            end
            if (cmd.emit_none)
            begin
                active_reg      <= 1'b0;
                resp_reg        <= '{base_hi: '0, base_lo: '0, prefix_len: '0,
                                     last: 1'b0, none: 1'b1};
            end
            if (cmd.advance)
            begin
                cursor_reg          <= sum[AW-1:0];
                active_reg          <= ~last;
                resp_reg.base_hi    <= cursor_reg[AW-1:HW];
                resp_reg.base_lo    <= cursor_reg[HW-1:0];
                resp_reg.prefix_len <= ADDR_BITS - k_reg;
                resp_reg.last       <= last;
                resp_reg.none       <= 1'b0;
            end
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= ADDR_BITS)
        else $error("block exponent out of range");

    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp.none |-> resp.prefix_len == 8'd0 && !resp.last && !active_reg)
        else $error("empty result carries data or leaves the range active");

    a_live_after: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp.none && !resp.last |-> active_reg)
        else $error("range closed without a final prefix");

endmodule
